/* design/assert_macros.svh */
// Assertion macros used by the decoder top level.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/dht11_etd_pkg.sv */
// Package for the single-wire sensor edge timing decoder.
// Status codes, register indexes, reset values and window compare helper.
package dht11_etd_pkg;

    localparam int CFG_W    = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam int RETRY_LIMIT_DEFAULT = 20;

    localparam logic [5:0] TOTAL_BITS = 6'd40;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOSTART  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADPULSE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd6;

    // Input command codes (tuser)
    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_EDGE  = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_START_MIN     = 3'd0,
        REG_START_MAX     = 3'd1,
        REG_BIT_LOW_MIN   = 3'd2,
        REG_BIT_LOW_MAX   = 3'd3,
        REG_ZERO_HIGH_MIN = 3'd4,
        REG_ZERO_HIGH_MAX = 3'd5,
        REG_ONE_HIGH_MIN  = 3'd6,
        REG_ONE_HIGH_MAX  = 3'd7
    } reg_index_t;

    localparam logic [CFG_W-1:0] START_MIN_RST     = 16'd60;
    localparam logic [CFG_W-1:0] START_MAX_RST     = 16'd100;
    localparam logic [CFG_W-1:0] BIT_LOW_MIN_RST   = 16'd30;
    localparam logic [CFG_W-1:0] BIT_LOW_MAX_RST   = 16'd70;
    localparam logic [CFG_W-1:0] ZERO_HIGH_MIN_RST = 16'd10;
    localparam logic [CFG_W-1:0] ZERO_HIGH_MAX_RST = 16'd45;
    localparam logic [CFG_W-1:0] ONE_HIGH_MIN_RST  = 16'd50;
    localparam logic [CFG_W-1:0] ONE_HIGH_MAX_RST  = 16'd90;

    // Strict window test: lo < v < hi
    function automatic logic in_window(input logic [TIME_W-1:0] v,
                                       input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi);
        logic [TIME_W-1:0] lo_x;
        logic [TIME_W-1:0] hi_x;
        lo_x = {{(TIME_W-CFG_W){1'b0}}, lo};
        hi_x = {{(TIME_W-CFG_W){1'b0}}, hi};
        return (v > lo_x) && (v < hi_x);
    endfunction

endpackage

/* design/dht11_edge_timing_decoder_unit.sv */
// Top level of the single-wire sensor edge timing decoder.
// Depends on dht11_etd_pkg and assert_macros.svh.
//
// An accepted word's result is registered and valid in the cycle after acceptance.
// Throughput: one word per cycle unless the output stalls; each word is decoded by
// compares and one byte sum between the input handshake and the output register.
// Reset: asynchronous, active low; clears decode state, output valid and
// restores the default window registers. The data byte store is not reset.
`include "assert_macros.svh"

module dht11_edge_timing_decoder_unit
    import dht11_etd_pkg::*;
#(
    parameter int RETRY_LIMIT = RETRY_LIMIT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] edge_time
    input  logic        s_tuser,   // [0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] humidity_word, [31:16] temperature_word
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam logic [7:0] RETRY_MAX = 8'(RETRY_LIMIT);

    // configuration
    logic [CFG_W-1:0] start_min_reg, start_max_reg;
    logic [CFG_W-1:0] bit_low_min_reg, bit_low_max_reg;
    logic [CFG_W-1:0] zero_high_min_reg, zero_high_max_reg;
    logic [CFG_W-1:0] one_high_min_reg, one_high_max_reg;

    // decode state
    logic              active_reg, active_next;
    logic              start_found_reg, start_found_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic [TIME_W-1:0] held_low_reg, held_low_next;
    logic [7:0]        shift_byte_reg, shift_byte_next;
    logic [5:0]        bit_count_reg, bit_count_next;
    logic [7:0]        retry_count_reg, retry_count_next;
    logic [7:0]        data_bytes [4];

    logic              byte_we;
    logic [1:0]        byte_addr;

    // output register
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [15:0]         hum_reg, hum_next;
    logic [15:0]         tmp_reg, tmp_next;

    logic              accept;
    logic [TIME_W-1:0] dur;
    logic [7:0]        retry_inc;
    logic              low_ok;
    logic              is_zero;
    logic              is_one;
    logic [7:0]        shift_new;
    logic [5:0]        count_new;
    logic [7:0]        byte_sum;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign dur       = s_tdata - last_time_reg;
    assign retry_inc = retry_count_reg + 8'd1;
    assign low_ok    = in_window(held_low_reg, bit_low_min_reg, bit_low_max_reg);
    assign is_zero   = low_ok && in_window(dur, zero_high_min_reg, zero_high_max_reg);
    assign is_one    = low_ok && in_window(dur, one_high_min_reg, one_high_max_reg);
    assign shift_new = {shift_byte_reg[6:0], !is_zero};
    assign count_new = bit_count_reg + 6'd1;
    assign byte_sum  = data_bytes[0] + data_bytes[1] + data_bytes[2] + data_bytes[3];

    always_comb
    begin
        active_next      = active_reg;
        start_found_next = start_found_reg;
        last_time_next   = last_time_reg;
        held_low_next    = held_low_reg;
        shift_byte_next  = shift_byte_reg;
        bit_count_next   = bit_count_reg;
        retry_count_next = retry_count_reg;
        byte_we          = 1'b0;
        byte_addr        = 2'(count_new[5:3] - 3'd1);
        status_next      = ST_BUSY;
        hum_next         = '0;
        tmp_next         = '0;

        if (s_tuser == FUNC_BEGIN)
        begin
            active_next      = 1'b1;
            start_found_next = 1'b0;
            last_time_next   = '0;
            held_low_next    = '0;
            shift_byte_next  = '0;
            bit_count_next   = '0;
            retry_count_next = '0;
        end
        else if (!active_reg)
        begin
            status_next = ST_IDLE;
        end
        else if (dur == '0)
        begin
            active_next = 1'b0;
            status_next = ST_ZERO;
        end
        else
        begin
            last_time_next = s_tdata;
            if (!start_found_reg)
            begin
                if (in_window(held_low_reg, start_min_reg, start_max_reg)
                    && in_window(dur, start_min_reg, start_max_reg))
                begin
                    start_found_next = 1'b1;
                    held_low_next    = '0;
                end
                else
                begin
                    held_low_next    = dur;
                    retry_count_next = retry_inc;
                    if (retry_inc >= RETRY_MAX)
                    begin
                        active_next = 1'b0;
                        status_next = ST_NOSTART;
                    end
                end
            end
            else if (held_low_reg == '0)
            begin
                held_low_next = dur;
            end
            else if (!is_zero && !is_one)
            begin
                active_next = 1'b0;
                status_next = ST_BADPULSE;
            end
            else
            begin
                held_low_next   = '0;
                shift_byte_next = shift_new;
                bit_count_next  = count_new;
                if (count_new < TOTAL_BITS)
                begin
                    // byte boundary: store the finished byte
                    if (count_new[2:0] == 3'd0)
                    begin
                        byte_we         = 1'b1;
                        shift_byte_next = '0;
                    end
                end
                else
                begin
                    active_next = 1'b0;
                    if (byte_sum != shift_new)
                    begin
                        status_next = ST_CHECKSUM;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        hum_next    = {data_bytes[0], data_bytes[1]};
                        tmp_next    = {data_bytes[2], data_bytes[3]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg     <= START_MIN_RST;
            start_max_reg     <= START_MAX_RST;
            bit_low_min_reg   <= BIT_LOW_MIN_RST;
            bit_low_max_reg   <= BIT_LOW_MAX_RST;
            zero_high_min_reg <= ZERO_HIGH_MIN_RST;
            zero_high_max_reg <= ZERO_HIGH_MAX_RST;
            one_high_min_reg  <= ONE_HIGH_MIN_RST;
            one_high_max_reg  <= ONE_HIGH_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_START_MIN:     start_min_reg     <= cfg_data;
                REG_START_MAX:     start_max_reg     <= cfg_data;
                REG_BIT_LOW_MIN:   bit_low_min_reg   <= cfg_data;
                REG_BIT_LOW_MAX:   bit_low_max_reg   <= cfg_data;
                REG_ZERO_HIGH_MIN: zero_high_min_reg <= cfg_data;
                REG_ZERO_HIGH_MAX: zero_high_max_reg <= cfg_data;
                REG_ONE_HIGH_MIN:  one_high_min_reg  <= cfg_data;
                REG_ONE_HIGH_MAX:  one_high_max_reg  <= cfg_data;
                default:           start_min_reg     <= start_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            start_found_reg <= 1'b0;
            last_time_reg   <= '0;
            held_low_reg    <= '0;
            shift_byte_reg  <= '0;
            bit_count_reg   <= '0;
            retry_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                active_reg      <= active_next;
                start_found_reg <= start_found_next;
                last_time_reg   <= last_time_next;
                held_low_reg    <= held_low_next;
                shift_byte_reg  <= shift_byte_next;
                bit_count_reg   <= bit_count_next;
                retry_count_reg <= retry_count_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload and byte store carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            hum_reg    <= hum_next;
            tmp_reg    <= tmp_next;
            if (byte_we)
            begin
                data_bytes[byte_addr] <= shift_new;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {tmp_reg, hum_reg};

    `ASSERT_ALWAYS(a_bit_count_range, clk, rst_n, bit_count_reg <= TOTAL_BITS,
        "bit count past frame length")
    `ASSERT_ALWAYS(a_found_below_limit, clk, rst_n,
        !start_found_reg || (retry_count_reg < RETRY_MAX),
        "start found with retries exhausted")
    `ASSERT_ALWAYS(a_shift_clear_on_boundary, clk, rst_n,
        !((bit_count_reg[2:0] == 3'd0) && (bit_count_reg < TOTAL_BITS))
            || (shift_byte_reg == 8'd0),
        "shift byte not cleared at byte boundary")
    `ASSERT_NEXT(a_begin_busy, clk, rst_n, accept && (s_tuser == FUNC_BEGIN),
        m_tvalid && (m_tuser == ST_BUSY) && active_reg,
        "begin word did not give busy result")
    `ASSERT_ALWAYS(a_payload_zero_unless_done, clk, rst_n,
        !m_tvalid || (m_tuser == ST_DONE) || (m_tdata == 32'd0),
        "payload set without done status")

endmodule
